[rtl/core/itad_pkg.sv]
// itad_pkg: shared types and constants for the integer to ASCII digit core.
// Used by itad_front, itad_queue, itad_back and integer_to_ascii_digits_core.
package itad_pkg;

    localparam int DATA_W        = 64;
    localparam int KIND_W        = 2;
    localparam int REQ_W         = 5;
    localparam int CHAR_W        = 7;
    localparam int MAX_DIGITS    = 20;
    localparam int BCD_W         = MAX_DIGITS * 4;
    localparam int LEN_W         = $clog2(MAX_DIGITS + 1);
    localparam int BITS_PER_STEP = 4;
    localparam int CONV_STEPS    = DATA_W / BITS_PER_STEP;
    localparam int STEP_CNT_W    = $clog2(CONV_STEPS);
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = 1;
    localparam int QCNT_W        = 2;

    localparam logic [KIND_W-1:0] KIND_SDEC      = 2'd0;
    localparam logic [KIND_W-1:0] KIND_UDEC      = 2'd1;
    localparam logic [KIND_W-1:0] KIND_HEX_LOWER = 2'd2;
    localparam logic [KIND_W-1:0] KIND_HEX_UPPER = 2'd3;

    localparam logic [CHAR_W-1:0] ASCII_ZERO    = 7'h30;
    localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 7'h61;
    localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 7'h41;

    typedef struct packed {
        logic              hex;
        logic              upper;
        logic [DATA_W-1:0] mag;
        logic [LEN_W-1:0]  req;
    } item_t;

endpackage

[rtl/core/integer_to_ascii_digits_core.sv]
// integer_to_ascii_digits_core: 64-bit integer to ASCII decimal or hex digits.
// Decimal numbers pass the BCD shift-add-3 unit, then a length search; hex numbers
//   skip the unit. Digits then leave one a cycle while out_ready is high.
// A two-entry queue lets numbers be accepted while the back end converts and emits.
// Reset (rst_n low, asynchronous): queue empty, converter idle, no output valid.
module integer_to_ascii_digits_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [itad_pkg::KIND_W-1:0]   kind,
    input  logic [itad_pkg::DATA_W-1:0]   value,
    input  logic [itad_pkg::REQ_W-1:0]    requested_len,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [itad_pkg::CHAR_W-1:0]   character,
    output logic                          last
);

    itad_pkg::item_t push_item;
    itad_pkg::item_t head;
    logic            push;
    logic            pop;
    logic            empty;
    logic            full;

    itad_front u_front
    (
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .kind          (kind),
        .value         (value),
        .requested_len (requested_len),
        .queue_full    (full),
        .push          (push),
        .item          (push_item)
    );

    itad_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .empty     (empty),
        .full      (full)
    );

    itad_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (empty),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .character (character),
        .last      (last)
    );

endmodule

[rtl/core/itad_front.sv]
// itad_front: accepts a number, forms its magnitude and saturated length request.
// Depends on itad_pkg; feeds itad_queue.
module itad_front
(
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [itad_pkg::KIND_W-1:0]   kind,
    input  logic [itad_pkg::DATA_W-1:0]   value,
    input  logic [itad_pkg::REQ_W-1:0]    requested_len,
    input  logic                          queue_full,
    output logic                          push,
    output itad_pkg::item_t               item
);

    logic negative;

    assign in_ready = !queue_full;
    assign push     = in_valid && !queue_full;
    assign negative = (kind == itad_pkg::KIND_SDEC) && value[itad_pkg::DATA_W-1];

    always_comb
    begin
        item.hex   = (kind == itad_pkg::KIND_HEX_LOWER) || (kind == itad_pkg::KIND_HEX_UPPER);
        item.upper = (kind == itad_pkg::KIND_HEX_UPPER);
        item.mag   = negative ? (~value + itad_pkg::DATA_W'(1)) : value;
        if (32'(requested_len) > itad_pkg::MAX_DIGITS)
        begin
            item.req = itad_pkg::LEN_W'(itad_pkg::MAX_DIGITS);
        end
        else
        begin
            item.req = itad_pkg::LEN_W'(requested_len);
        end
    end

endmodule

[rtl/core/itad_queue.sv]
// itad_queue: two-entry queue between front and back of the digit core.
// Depends on itad_pkg.
module itad_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  itad_pkg::item_t push_item,
    input  logic            pop,
    output itad_pkg::item_t head,
    output logic            empty,
    output logic            full
);

    itad_pkg::item_t                  entry_reg [itad_pkg::QUEUE_DEPTH];
    logic [itad_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [itad_pkg::QPTR_W-1:0]      wr_ptr_next;
    logic [itad_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [itad_pkg::QPTR_W-1:0]      rd_ptr_next;
    logic [itad_pkg::QCNT_W-1:0]      count_reg;
    logic [itad_pkg::QCNT_W-1:0]      count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == itad_pkg::QCNT_W'(itad_pkg::QUEUE_DEPTH));
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= itad_pkg::QCNT_W'(itad_pkg::QUEUE_DEPTH))
        else $error("queue count overflow");

    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("pop from empty queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != itad_pkg::QCNT_W'(itad_pkg::QUEUE_DEPTH)))
        else $error("push into full queue");

endmodule

[rtl/core/itad_back.sv]
// itad_back: binary to BCD conversion of decimal numbers (4 bits a cycle), length search and digit emit.
// Depends on itad_pkg; reads the head of itad_queue.
module itad_back
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  itad_pkg::item_t               head,
    input  logic                          empty,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [itad_pkg::CHAR_W-1:0]   character,
    output logic                          last
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_FIND = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]                          state_reg;
    logic [1:0]                          state_next;
    logic [itad_pkg::BCD_W-1:0]          bcd_reg;
    logic [itad_pkg::BCD_W-1:0]          bcd_next;
    logic [itad_pkg::DATA_W-1:0]         bin_reg;
    logic [itad_pkg::DATA_W-1:0]         bin_next;
    logic [itad_pkg::STEP_CNT_W-1:0]     step_reg;
    logic [itad_pkg::STEP_CNT_W-1:0]     step_next;
    logic                                upper_reg;
    logic                                upper_next;
    logic [itad_pkg::LEN_W-1:0]          req_reg;
    logic [itad_pkg::LEN_W-1:0]          req_next;
    logic [itad_pkg::LEN_W-1:0]          pos_reg;
    logic [itad_pkg::LEN_W-1:0]          pos_next;
    logic                                out_valid_reg;
    logic                                out_valid_next;
    logic [itad_pkg::CHAR_W-1:0]         char_reg;
    logic [itad_pkg::CHAR_W-1:0]         char_next;
    logic                                last_reg;
    logic                                last_next;

    logic [itad_pkg::BCD_W-1:0]          dabble;
    logic [itad_pkg::LEN_W-1:0]          natural;
    logic [itad_pkg::LEN_W-1:0]          len;
    logic [3:0]                          cur_digit;
    logic [itad_pkg::CHAR_W-1:0]         cur_char;
    logic                                emit;

    assign out_valid = out_valid_reg;
    assign character = char_reg;
    assign last      = last_reg;
    assign pop       = (state_reg == ST_IDLE) && !empty;
    assign emit      = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);

    // shift-add-3 over four input bits
    always_comb
    begin
        logic [itad_pkg::DATA_W-1:0] b;
        dabble = bcd_reg;
        b      = bin_reg;
        for (int s = 0; s < itad_pkg::BITS_PER_STEP; s++)
        begin
            for (int d = 0; d < itad_pkg::MAX_DIGITS; d++)
            begin
                if (dabble[4*d +: 4] >= 4'd5)
                begin
                    dabble[4*d +: 4] = dabble[4*d +: 4] + 4'd3;
                end
            end
            dabble = {dabble[itad_pkg::BCD_W-2:0], b[itad_pkg::DATA_W-1]};
            b      = {b[itad_pkg::DATA_W-2:0], 1'b0};
        end
    end

    always_comb
    begin
        natural = itad_pkg::LEN_W'(1);
        for (int d = 1; d < itad_pkg::MAX_DIGITS; d++)
        begin
            if (bcd_reg[4*d +: 4] != 4'd0)
            begin
                natural = itad_pkg::LEN_W'(d + 1);
            end
        end
        len = (req_reg > natural) ? req_reg : natural;
    end

    always_comb
    begin
        cur_digit = bcd_reg[4*pos_reg +: 4];
        if (cur_digit < 4'd10)
        begin
            cur_char = itad_pkg::ASCII_ZERO + itad_pkg::CHAR_W'(cur_digit);
        end
        else if (upper_reg)
        begin
            cur_char = itad_pkg::ASCII_UPPER_A + itad_pkg::CHAR_W'(cur_digit - 4'd10);
        end
        else
        begin
            cur_char = itad_pkg::ASCII_LOWER_A + itad_pkg::CHAR_W'(cur_digit - 4'd10);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        bcd_next       = bcd_reg;
        bin_next       = bin_reg;
        step_next      = step_reg;
        upper_next     = upper_reg;
        req_next       = req_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg && !out_ready;
        char_next      = char_reg;
        last_next      = last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!empty)
                begin
                    upper_next = head.upper;
                    req_next   = head.req;
                    step_next  = '0;
                    bin_next   = head.mag;
                    if (head.hex)
                    begin
                        bcd_next   = itad_pkg::BCD_W'(head.mag);
                        state_next = ST_FIND;
                    end
                    else
                    begin
                        bcd_next   = '0;
                        state_next = ST_CONV;
                    end
                end
            end
            ST_CONV:
            begin
                bcd_next  = dabble;
                bin_next  = bin_reg << itad_pkg::BITS_PER_STEP;
                step_next = step_reg + 1'b1;
                if (step_reg == itad_pkg::STEP_CNT_W'(itad_pkg::CONV_STEPS - 1))
                begin
                    state_next = ST_FIND;
                end
            end
            ST_FIND:
            begin
                pos_next   = len - 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (emit)
                begin
                    out_valid_next = 1'b1;
                    char_next      = cur_char;
                    last_next      = (pos_reg == '0);
                    if (pos_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        pos_next = pos_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bcd_reg   <= bcd_next;
        bin_reg   <= bin_next;
        step_reg  <= step_next;
        upper_reg <= upper_next;
        req_reg   <= req_next;
        pos_reg   <= pos_next;
        char_reg  <= char_next;
        last_reg  <= last_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (pos_reg < itad_pkg::LEN_W'(itad_pkg::MAX_DIGITS)))
        else $error("digit position out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (emit && (pos_reg == '0)) |=> (state_reg == ST_IDLE) && out_valid_reg && last_reg)
        else $error("final digit not flagged");

    assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (state_reg == ST_CONV) || (state_reg == ST_FIND))
        else $error("item taken without starting conversion");

endmodule
